FILE: rtl/lmde_pkg.sv
// package for the layered modulated delay effect: types, constants, helpers
package lmde_pkg;

	localparam int BufDepth   = 256;
	localparam int MaxLayers  = 32;
	localparam int LayerCap   = 20;
	localparam int ClipQ23    = 1862271;
	localparam int OneQ23     = 8388608;

	localparam logic [2:0] CfgPreGain    = 3'd0;
	localparam logic [2:0] CfgPostGain   = 3'd1;
	localparam logic [2:0] CfgDelayLen   = 3'd2;
	localparam logic [2:0] CfgLayerCount = 3'd3;
	localparam logic [2:0] CfgBoost      = 3'd4;
	localparam logic [2:0] CfgSmoothing  = 3'd5;
	localparam logic [2:0] CfgWetMix     = 3'd6;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PRE0,
		ST_PRE1,
		ST_PRE2,
		ST_LRD,
		ST_LBOOST,
		ST_LCLAMP,
		ST_LENV0,
		ST_LENV1,
		ST_LENV2,
		ST_LTAP0,
		ST_LTAP1,
		ST_LRD2,
		ST_LMIX0,
		ST_LMIX1,
		ST_LWB,
		ST_SM0,
		ST_PST0,
		ST_PST1,
		ST_PST2,
		ST_MIX0,
		ST_MIX1,
		ST_OUT
	} state_t;

	// one command per state, decoded by the datapath
	typedef struct packed {
		state_t op;
		logic   clr_step;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic last_layer;
		logic no_layers;
	} status_t;

	// arithmetic shift right with round half up
	function automatic logic signed [79:0] rnd_shift(input logic signed [79:0] v,
		input int n);
		logic signed [79:0] t;
		t = v + (80'sd1 <<< (n - 1));
		return t >>> n;
	endfunction

	function automatic logic signed [79:0] clamp(input logic signed [79:0] v,
		input logic signed [79:0] lim);
		logic signed [79:0] r;
		r = v;
		if (v > lim) r = lim;
		if (v < -lim) r = -lim;
		return r;
	endfunction

endpackage

FILE: rtl/layered_modulated_delay_effect.sv
// top level of the layered modulated delay effect
//  channel | signals                       | accepted when
//  in      | in_valid in_stall sample_in   | in_valid && !in_stall
//  out     | out_valid out_stall sample_out| out_valid && !out_stall
//  cfg     | cfg_valid cfg_ready cfg_index | cfg_valid && cfg_ready
// the result is valid once pre-gain, every active layer, smoothing, post-gain and the mix have run
// one item occupies the block until its result is taken; no new item is accepted meanwhile
// reset starts a clearing pass over the delay memory
// in_stall is high while an item is at work or its result waits
module layered_modulated_delay_effect #(
	parameter int BUF_DEPTH  = lmde_pkg::BufDepth,
	parameter int MAX_LAYERS = lmde_pkg::MaxLayers
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] sample_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] sample_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	logic [47:0] pre_gain_q, post_gain_q;
	logic [7:0]  delay_len_q;
	logic [4:0]  layer_count_q;
	logic [15:0] boost_q;
	logic [16:0] smoothing_q, wet_mix_q;
	logic signed [23:0] dry_q;
	lmde_pkg::cmd_t cmd;
	lmde_pkg::status_t sts;
	logic idle;

	assign cfg_ready = 1'b1;
	assign in_stall = !idle;
	assign out_valid = (cmd.op == lmde_pkg::ST_OUT);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_gain_q <= 48'd107374;
			post_gain_q <= 48'd2621440000;
			delay_len_q <= 8'd90;
			layer_count_q <= 5'd4;
			boost_q <= 16'd17203;
			smoothing_q <= 17'd16384;
			wet_mix_q <= 17'd65536;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					lmde_pkg::CfgPreGain: pre_gain_q <= cfg_data;
					lmde_pkg::CfgPostGain: post_gain_q <= cfg_data;
					lmde_pkg::CfgDelayLen: delay_len_q <= cfg_data[7:0];
					lmde_pkg::CfgLayerCount: layer_count_q <= cfg_data[4:0];
					lmde_pkg::CfgBoost: boost_q <= cfg_data[15:0];
					lmde_pkg::CfgSmoothing: smoothing_q <= cfg_data[16:0];
					lmde_pkg::CfgWetMix: wet_mix_q <= cfg_data[16:0];
					default: ;
				endcase
			end
		end
	end

	// capture the dry sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dry_q <= '0;
		else if (idle && in_valid) dry_q <= sample_in;
	end

	lmde_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_valid), .out_busy(out_stall),
		.sts(sts), .cmd(cmd), .idle(idle)
	);

	lmde_dp #(.BUF_DEPTH(BUF_DEPTH), .MAX_LAYERS(MAX_LAYERS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .dry(dry_q),
		.pre_gain(pre_gain_q), .post_gain(post_gain_q), .delay_len(delay_len_q),
		.layer_count(layer_count_q), .boost(boost_q), .smoothing(smoothing_q),
		.wet_mix(wet_mix_q), .result(sample_out)
	);

	// output holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("result changed under stall");
	// no new item while a result waits
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during output");

endmodule

FILE: rtl/lmde_ctrl.sv
// controller state machine sequencing pre-gain, the layers and the output path
module lmde_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_go,
	input  logic                out_busy,
	input  lmde_pkg::status_t   sts,
	output lmde_pkg::cmd_t      cmd,
	output logic                idle
);

	lmde_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lmde_pkg::ST_CLEAR;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd.op = state_q;
		cmd.clr_step = 1'b0;
		idle = 1'b0;
		case (state_q)
			lmde_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = lmde_pkg::ST_IDLE;
			end
			lmde_pkg::ST_IDLE: begin
				idle = 1'b1;
				if (in_go) state_d = lmde_pkg::ST_PRE0;
			end
			lmde_pkg::ST_PRE0: state_d = lmde_pkg::ST_PRE1;
			lmde_pkg::ST_PRE1: state_d = lmde_pkg::ST_PRE2;
			lmde_pkg::ST_PRE2: state_d = sts.no_layers ? lmde_pkg::ST_SM0 : lmde_pkg::ST_LRD;
			lmde_pkg::ST_LRD: state_d = lmde_pkg::ST_LBOOST;
			lmde_pkg::ST_LBOOST: state_d = lmde_pkg::ST_LCLAMP;
			lmde_pkg::ST_LCLAMP: state_d = lmde_pkg::ST_LENV0;
			lmde_pkg::ST_LENV0: state_d = lmde_pkg::ST_LENV1;
			lmde_pkg::ST_LENV1: state_d = lmde_pkg::ST_LENV2;
			lmde_pkg::ST_LENV2: state_d = lmde_pkg::ST_LTAP0;
			lmde_pkg::ST_LTAP0: state_d = lmde_pkg::ST_LTAP1;
			lmde_pkg::ST_LTAP1: state_d = lmde_pkg::ST_LRD2;
			lmde_pkg::ST_LRD2: state_d = lmde_pkg::ST_LMIX0;
			lmde_pkg::ST_LMIX0: state_d = lmde_pkg::ST_LMIX1;
			lmde_pkg::ST_LMIX1: state_d = lmde_pkg::ST_LWB;
			lmde_pkg::ST_LWB: state_d = sts.last_layer ? lmde_pkg::ST_SM0 : lmde_pkg::ST_LRD;
			lmde_pkg::ST_SM0: state_d = lmde_pkg::ST_PST0;
			lmde_pkg::ST_PST0: state_d = lmde_pkg::ST_PST1;
			lmde_pkg::ST_PST1: state_d = lmde_pkg::ST_PST2;
			lmde_pkg::ST_PST2: state_d = lmde_pkg::ST_MIX0;
			lmde_pkg::ST_MIX0: state_d = lmde_pkg::ST_MIX1;
			lmde_pkg::ST_MIX1: state_d = lmde_pkg::ST_OUT;
			lmde_pkg::ST_OUT: if (!out_busy) state_d = lmde_pkg::ST_IDLE;
			default: state_d = lmde_pkg::ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/lmde_dp.sv
// datapath: delay memory, per-layer state, product registers shared by all steps
module lmde_dp #(
	parameter int BUF_DEPTH  = lmde_pkg::BufDepth,
	parameter int MAX_LAYERS = lmde_pkg::MaxLayers
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lmde_pkg::cmd_t      cmd,
	output lmde_pkg::status_t   sts,
	input  logic signed [23:0]  dry,
	input  logic [47:0]         pre_gain,
	input  logic [47:0]         post_gain,
	input  logic [7:0]          delay_len,
	input  logic [4:0]          layer_count,
	input  logic [15:0]         boost,
	input  logic [16:0]         smoothing,
	input  logic [16:0]         wet_mix,
	output logic signed [23:0]  result
);

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int LW = $clog2(MAX_LAYERS);
	localparam int MW = LW + AW;
	localparam int PW = (AW + 1 > 8) ? AW + 1 : 8;

	typedef logic signed [79:0] w_t;

	// memories
	logic signed [23:0] line_mem [MAX_LAYERS * BUF_DEPTH];
	logic [PW-1:0]      wp_mem  [MAX_LAYERS];
	logic [23:0]        pos_mem [MAX_LAYERS];
	logic [23:0]        lev_mem [MAX_LAYERS];

	logic [MW:0]        clr_q;
	logic [LW-1:0]      layer_q;
	logic [PW-1:0]      len, wp_q, i1_q, i2_q;
	logic [4:0]         layers;
	logic [16:0]        f, g, w;
	logic signed [24:0] x_q;
	logic [23:0]        pos_q, lev_q;
	logic signed [31:0] smooth_q;
	w_t                 acc_q, prod_q, tmp_q;
	logic signed [23:0] rd_q;
	logic signed [23:0] tap_q;
	logic signed [23:0] t1_q;
	logic [22:0]        fr_q;

	// effective configuration
	always_comb begin
		len = PW'(delay_len == 8'd0 ? 8'd1 : delay_len);
		if (len > PW'(BUF_DEPTH)) len = PW'(BUF_DEPTH);
		layers = (layer_count > 5'(lmde_pkg::LayerCap)) ? 5'(lmde_pkg::LayerCap)
			: layer_count;
		f = (smoothing == 17'd0) ? 17'd1 : ((smoothing > 17'd65536) ? 17'd65536 : smoothing);
		g = 17'd65536 - f;
		w = (wet_mix > 17'd65536) ? 17'd65536 : wet_mix;
	end

	assign sts.clr_done   = clr_q[MW];
	assign sts.last_layer = ({1'b0, layer_q} + (LW + 1)'(1)) >= (LW + 1)'(layers);
	assign sts.no_layers  = (layers == 5'd0);
	assign result = rd_q;

	logic [MW-1:0] addr;
	logic [PW+23:0] p;
	logic [PW-1:0] d, d1, d2, wpe;

	// address math for taps
	always_comb begin
		wpe = (wp_q >= len) ? '0 : wp_q;
		p = pos_q * len;
		d = PW'(p >> 23);
		d1 = (d >= len) ? d - len : d;
		d2 = (d + PW'(1) >= len) ? d + PW'(1) - len : d + PW'(1);
		addr = {layer_q, AW'(0)};
	end

	w_t pre_v, term_v, mix_v;
	logic signed [24:0] pre_x;
	logic signed [23:0] boost_x, mix_x;

	// rounding and saturation of the multiplier results
	always_comb begin
		pre_v = lmde_pkg::clamp(acc_q, w_t'(lmde_pkg::OneQ23));
		if (pre_v > w_t'(lmde_pkg::OneQ23 - 1)) pre_v = w_t'(lmde_pkg::OneQ23 - 1);
		pre_x = 25'(pre_v);
		boost_x = 24'(lmde_pkg::clamp(lmde_pkg::rnd_shift(prod_q, 14),
			w_t'(lmde_pkg::ClipQ23)));
		term_v = lmde_pkg::rnd_shift(w_t'(x_q) * w_t'(t1_q), 23);
		if (term_v < 0) term_v = -term_v;
		mix_v = lmde_pkg::rnd_shift(prod_q + tmp_q, 16);
		if (mix_v > w_t'(lmde_pkg::OneQ23 - 1)) mix_v = w_t'(lmde_pkg::OneQ23 - 1);
		if (mix_v < -w_t'(lmde_pkg::OneQ23)) mix_v = -w_t'(lmde_pkg::OneQ23);
		mix_x = 24'(mix_v);
	end

	// memory writes, clearing pass and registered tap reads
	always_ff @(posedge clk) begin
		if (cmd.clr_step && !clr_q[MW]) begin
			line_mem[clr_q[MW-1:0]] <= '0;
			if (clr_q[MW-1:LW] == '0) begin
				wp_mem[clr_q[LW-1:0]] <= PW'(1);
				pos_mem[clr_q[LW-1:0]] <= '0;
				lev_mem[clr_q[LW-1:0]] <= '0;
			end
		end
		case (cmd.op)
			lmde_pkg::ST_LCLAMP: line_mem[addr + MW'(wp_q)] <= boost_x;
			lmde_pkg::ST_LTAP1: tap_q <= line_mem[addr + MW'(i1_q)];
			lmde_pkg::ST_LRD2: tap_q <= line_mem[addr + MW'(i2_q)];
			lmde_pkg::ST_LWB: begin
				wp_mem[layer_q] <= (wp_q + PW'(1) >= len) ? '0 : wp_q + PW'(1);
				pos_mem[layer_q] <= pos_q;
				lev_mem[layer_q] <= lev_q;
			end
			default: ;
		endcase
	end

	// sequenced datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			smooth_q <= '0;
			layer_q <= '0;
			wp_q <= '0;
			pos_q <= '0;
			lev_q <= '0;
			i1_q <= '0;
			i2_q <= '0;
			x_q <= '0;
			acc_q <= '0;
			prod_q <= '0;
			tmp_q <= '0;
			rd_q <= '0;
			t1_q <= '0;
			fr_q <= '0;
		end else begin
			if (cmd.clr_step && !clr_q[MW]) clr_q <= clr_q + 1'b1;
			case (cmd.op)
				lmde_pkg::ST_PRE0: begin
					layer_q <= '0;
					prod_q <= w_t'(dry) * w_t'({1'b0, pre_gain[47:24]});
					tmp_q <= w_t'(dry) * w_t'({1'b0, pre_gain[23:0]});
				end
				lmde_pkg::ST_PRE1: acc_q <= prod_q + lmde_pkg::rnd_shift(tmp_q, 24);
				lmde_pkg::ST_PRE2: x_q <= pre_x;
				lmde_pkg::ST_LRD: begin
					wp_q <= wp_mem[layer_q];
					pos_q <= pos_mem[layer_q];
					lev_q <= lev_mem[layer_q];
				end
				lmde_pkg::ST_LBOOST: begin
					wp_q <= wpe;
					prod_q <= w_t'(x_q) * w_t'({1'b0, boost});
				end
				lmde_pkg::ST_LCLAMP: x_q <= 25'(boost_x);
				lmde_pkg::ST_LENV0: begin
					acc_q <= w_t'({1'b0, pos_q}) * w_t'({1'b0, g})
						+ w_t'({1'b0, lev_q}) * w_t'({1'b0, f}) + 80'sd32768;
					t1_q <= 24'(lmde_pkg::rnd_shift(w_t'(x_q), 2) - w_t'(lmde_pkg::OneQ23 / 2));
				end
				lmde_pkg::ST_LENV1: begin
					pos_q <= 24'(acc_q >>> 16);
					prod_q <= term_v;
				end
				lmde_pkg::ST_LENV2: begin
					acc_q <= w_t'({1'b0, lev_q}) * w_t'({1'b0, g})
						+ prod_q * w_t'({1'b0, f}) + 80'sd32768;
				end
				lmde_pkg::ST_LTAP0: begin
					lev_q <= 24'(acc_q >>> 16);
					fr_q <= p[22:0];
					i1_q <= (wp_q >= d1) ? wp_q - d1 : wp_q + len - d1;
					i2_q <= (wp_q >= d2) ? wp_q - d2 : wp_q + len - d2;
				end
				lmde_pkg::ST_LRD2:
					prod_q <= w_t'(tap_q) * w_t'({1'b0, 24'(lmde_pkg::OneQ23) - {1'b0, fr_q}});
				lmde_pkg::ST_LMIX0: tmp_q <= w_t'(tap_q) * w_t'({1'b0, fr_q});
				lmde_pkg::ST_LMIX1: x_q <= 25'(lmde_pkg::rnd_shift(prod_q + tmp_q, 23));
				lmde_pkg::ST_LWB: layer_q <= layer_q + 1'b1;
				lmde_pkg::ST_SM0: smooth_q <= 32'(lmde_pkg::rnd_shift(
					w_t'(smooth_q) * w_t'({1'b0, f}) + w_t'(x_q) * w_t'({1'b0, g}), 16));
				lmde_pkg::ST_PST0: begin
					prod_q <= w_t'(smooth_q) * w_t'({1'b0, post_gain[47:24]});
					tmp_q <= w_t'(smooth_q) * w_t'({1'b0, post_gain[23:0]});
				end
				lmde_pkg::ST_PST1: acc_q <= prod_q + lmde_pkg::rnd_shift(tmp_q, 24);
				lmde_pkg::ST_PST2: acc_q <= lmde_pkg::clamp(acc_q, 80'sd1 <<< 40);
				lmde_pkg::ST_MIX0: begin
					prod_q <= acc_q * w_t'({1'b0, w});
					tmp_q <= w_t'(dry) * w_t'({1'b0, 17'd65536 - w});
				end
				lmde_pkg::ST_MIX1: rd_q <= mix_x;
				default: ;
			endcase
		end
	end

endmodule
